/* hw/rtl/crcfp_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the checked frame parser.
package crcfp_pkg;

    localparam int HDR_BYTES     = 12;
    localparam int CRC_HDR_BYTES = 10;
    localparam int COUNT_W       = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAGIC       = 2'd0;
    localparam logic [1:0] REG_VERSION     = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    // Frame status codes, in the order they are checked.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_MAGIC     = 3'd2;
    localparam logic [2:0] ST_VERSION   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;
    localparam logic [2:0] ST_CRC       = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] magic;
        logic [7:0]  version;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [31:0] sequence_res;
        logic [15:0] payload_length;
        logic        last;
    } res_t;

    // Up to two results per accepted byte; the first always sits in res_a.
    typedef struct packed {
        logic valid_a;
        logic valid_b;
        res_t res_a;
        res_t res_b;
    } wr_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc16_checked_frame_parser_top.sv */
// Top level of the CRC-16 checked frame parser: configuration registers and channel wiring.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------------
//  byte    | byte_valid, byte_stall, in_byte,          | received bytes in
//          | end_of_buffer                             |
//  res     | res_valid, res_stall, kind, payload_byte, | payload bytes and frame status
//          | payload_index, status, frame_type,        |
//          | sequence_res, payload_length, last        |
//  cfg     | cfg_we, cfg_index, cfg_wdata              | register writes, no read-back
//
// One byte is taken per cycle while byte_stall is low; its CRC step and header checks
// are combinational between the parser registers and a four-entry result queue.
// A byte yields at most two results; the queue delivers one per transfer, so a
// payload byte ending the buffer yields two transfers out.
// byte_stall rises only when the queue has fewer than two free entries.
// Reset clears the parser state, the queue and the registers (max payload 1024).
module crc16_checked_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_buffer,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [2:0]  status,
    output logic [7:0]  frame_type,
    output logic [31:0] sequence_res,
    output logic [15:0] payload_length,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    crcfp_pkg::cfg_t cfg_reg;
    crcfp_pkg::wr_t  wr;
    crcfp_pkg::res_t res;
    logic space;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= '0;
            cfg_reg.version     <= '0;
            cfg_reg.max_payload <= crcfp_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crcfp_pkg::REG_MAGIC:       cfg_reg.magic       <= cfg_wdata;
                crcfp_pkg::REG_VERSION:     cfg_reg.version     <= cfg_wdata[7:0];
                crcfp_pkg::REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign byte_stall = !space;
    assign accept     = byte_valid && space;

    crcfp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .cfg           (cfg_reg),
        .wr            (wr)
    );

    crcfp_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .space     (space),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign kind           = res.kind;
    assign payload_byte   = res.payload_byte;
    assign payload_index  = res.payload_index;
    assign status         = res.status;
    assign frame_type     = res.frame_type;
    assign sequence_res   = res.sequence_res;
    assign payload_length = res.payload_length;
    assign last           = res.last;

endmodule

/* hw/rtl/crcfp_parser.sv */
// Header capture, running CRC and result generation for each received byte.
module crcfp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_buffer,
    input  crcfp_pkg::cfg_t      cfg,
    output crcfp_pkg::wr_t       wr
);

    logic [crcfp_pkg::COUNT_W-1:0] count_reg;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] magic_reg, magic_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] gcrc_reg, gcrc_next;

    logic [crcfp_pkg::COUNT_W-1:0] pay_end;
    logic [crcfp_pkg::COUNT_W:0]   total;
    logic in_hdr, in_crc_hdr, in_payload, hdr_ok, emit_pay;
    logic [2:0] st;
    crcfp_pkg::res_t pay_res, stat_res;

    assign in_hdr     = count_reg < crcfp_pkg::COUNT_W'(crcfp_pkg::HDR_BYTES);
    assign in_crc_hdr = count_reg < crcfp_pkg::COUNT_W'(crcfp_pkg::CRC_HDR_BYTES);

    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        length_next  = length_reg;
        gcrc_next    = gcrc_reg;
        if (in_hdr)
        begin
            case (count_reg[3:0])
                4'd0:    magic_next[7:0]    = in_byte;
                4'd1:    magic_next[15:8]   = in_byte;
                4'd2:    version_next       = in_byte;
                4'd3:    type_next          = in_byte;
                4'd4:    seq_next[7:0]      = in_byte;
                4'd5:    seq_next[15:8]     = in_byte;
                4'd6:    seq_next[23:16]    = in_byte;
                4'd7:    seq_next[31:24]    = in_byte;
                4'd8:    length_next[7:0]   = in_byte;
                4'd9:    length_next[15:8]  = in_byte;
                4'd10:   gcrc_next[7:0]     = in_byte;
                4'd11:   gcrc_next[15:8]    = in_byte;
                default: ;
            endcase
        end
    end

    assign pay_end    = crcfp_pkg::COUNT_W'({1'b0, length_next})
                        + crcfp_pkg::COUNT_W'(crcfp_pkg::HDR_BYTES);
    assign in_payload = !in_hdr && (count_reg < pay_end);
    assign crc_next   = (in_crc_hdr || in_payload) ? crcfp_pkg::crc16_byte(crc_reg, in_byte)
                                                   : crc_reg;
    assign hdr_ok     = (magic_next == cfg.magic) && (version_next == cfg.version)
                        && (length_next <= cfg.max_payload);
    assign emit_pay   = in_payload && hdr_ok;

    // Bytes seen including this one; one bit wider than the saturating count.
    assign total = {1'b0, count_reg} + (crcfp_pkg::COUNT_W+1)'(1);

    always_comb
    begin
        if (total < (crcfp_pkg::COUNT_W+1)'(crcfp_pkg::HDR_BYTES))
            st = crcfp_pkg::ST_SHORT;
        else if (magic_next != cfg.magic)
            st = crcfp_pkg::ST_MAGIC;
        else if (version_next != cfg.version)
            st = crcfp_pkg::ST_VERSION;
        else if (length_next > cfg.max_payload)
            st = crcfp_pkg::ST_TOO_LONG;
        else if (total < {1'b0, pay_end})
            st = crcfp_pkg::ST_TRUNCATED;
        else if (crc_next != gcrc_next)
            st = crcfp_pkg::ST_CRC;
        else
            st = crcfp_pkg::ST_OK;
    end

    always_comb
    begin
        pay_res               = '0;
        pay_res.kind          = crcfp_pkg::KIND_PAYLOAD;
        pay_res.payload_byte  = in_byte;
        pay_res.payload_index = 16'(count_reg - crcfp_pkg::COUNT_W'(crcfp_pkg::HDR_BYTES));
        pay_res.last          = !end_of_buffer;

        stat_res        = '0;
        stat_res.kind   = crcfp_pkg::KIND_STATUS;
        stat_res.status = st;
        stat_res.last   = 1'b1;
        // A short buffer reports no header fields.
        if (st != crcfp_pkg::ST_SHORT)
        begin
            stat_res.frame_type     = type_next;
            stat_res.sequence_res   = seq_next;
            stat_res.payload_length = length_next;
        end
    end

    assign wr.valid_a = accept && (emit_pay || end_of_buffer);
    assign wr.valid_b = accept && emit_pay && end_of_buffer;
    assign wr.res_a   = emit_pay ? pay_res : stat_res;
    assign wr.res_b   = stat_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= crcfp_pkg::CRC_INIT;
            magic_reg   <= '0;
            version_reg <= '0;
            type_reg    <= '0;
            seq_reg     <= '0;
            length_reg  <= '0;
            gcrc_reg    <= '0;
        end
        else if (accept)
        begin
            if (end_of_buffer)
            begin
                count_reg   <= '0;
                crc_reg     <= crcfp_pkg::CRC_INIT;
                magic_reg   <= '0;
                version_reg <= '0;
                type_reg    <= '0;
                seq_reg     <= '0;
                length_reg  <= '0;
                gcrc_reg    <= '0;
            end
            else
            begin
                if (count_reg != crcfp_pkg::COUNT_MAX)
                    count_reg <= count_reg + crcfp_pkg::COUNT_W'(1);
                crc_reg     <= crc_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                type_reg    <= type_next;
                seq_reg     <= seq_next;
                length_reg  <= length_next;
                gcrc_reg    <= gcrc_next;
            end
        end
    end

endmodule

/* hw/rtl/crcfp_res_fifo.sv */
// Small result queue: takes up to two results per cycle and delivers one per transfer.
module crcfp_res_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  crcfp_pkg::wr_t  wr,
    output logic            space,
    output logic            res_valid,
    input  logic            res_stall,
    output crcfp_pkg::res_t res
);

    crcfp_pkg::res_t mem_reg [crcfp_pkg::FIFO_DEPTH];
    logic [crcfp_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_b;
    logic [crcfp_pkg::CNT_W-1:0] count_reg, count_next;
    logic pop;

    // Room for two results is required before a byte may be taken.
    assign space     = count_reg <= crcfp_pkg::CNT_W'(crcfp_pkg::FIFO_DEPTH - 2);
    assign res_valid = count_reg != '0;
    assign res       = mem_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    assign wr_ptr_b  = wr_ptr_reg + crcfp_pkg::PTR_W'(1);

    assign count_next = count_reg + crcfp_pkg::CNT_W'(wr.valid_a)
                        + crcfp_pkg::CNT_W'(wr.valid_b) - crcfp_pkg::CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (wr.valid_a)
            mem_reg[wr_ptr_reg] <= wr.res_a;
        if (wr.valid_b)
            mem_reg[wr_ptr_b] <= wr.res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.valid_b)
                wr_ptr_reg <= wr_ptr_reg + crcfp_pkg::PTR_W'(2);
            else if (wr.valid_a)
                wr_ptr_reg <= wr_ptr_b;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + crcfp_pkg::PTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= crcfp_pkg::CNT_W'(crcfp_pkg::FIFO_DEPTH))
        else $error("result queue count exceeds its depth");

    a_push_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid_a |-> space)
        else $error("result pushed while the queue lacks room for two");

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid_b |-> wr.valid_a)
        else $error("second result written without a first");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !wr.valid_a) |=> (count_reg == $past(count_reg) - crcfp_pkg::CNT_W'(1)))
        else $error("queue count did not fall after a lone transfer out");

endmodule

/* dv/crc16_checked_frame_parser_top_tb.sv */
// Self-checking testbench for the CRC-16 checked frame parser: directed frames, then random traffic.
module crc16_checked_frame_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_BYTES = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_TRAIL = 40;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  in_byte;
    logic        end_of_buffer;
    logic        res_valid;
    logic        res_stall;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [31:0] sequence_res;
    logic [15:0] payload_length;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // The sink stalls either for its own per-transfer wait or for a long hold-off.
    logic rx_wait = 1'b0;
    logic rx_hold = 1'b0;
    assign res_stall = rx_wait | rx_hold;

    // Random idling of each side can be switched off for stretches of the run.
    bit tx_jitter = 1'b1;
    bit rx_jitter = 1'b1;
    int hold_req = 0;

    // Register copies and parser state of the prediction.
    logic [15:0] cur_magic = 16'h0000;
    logic [7:0]  cur_version = 8'h00;
    logic [15:0] cur_max_payload = crcfp_pkg::MAX_PAYLOAD_RESET;

    logic [crcfp_pkg::COUNT_W-1:0] m_count = '0;
    logic [15:0] m_crc = crcfp_pkg::CRC_INIT;
    logic [15:0] m_magic = '0;
    logic [7:0]  m_version = '0;
    logic [7:0]  m_type = '0;
    logic [31:0] m_seq = '0;
    logic [15:0] m_len = '0;
    logic [15:0] m_rx_crc = '0;

    crcfp_pkg::res_t pending_results[$];
    logic [7:0] frame_buf[$];

    int cycles = 0;
    int mismatches = 0;
    int bytes_in = 0;
    int payload_count = 0;
    int stall_cycles = 0;
    int status_count[0:7];

    crc16_checked_frame_parser_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .in_byte(in_byte),
        .end_of_buffer(end_of_buffer),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .kind(kind),
        .payload_byte(payload_byte),
        .payload_index(payload_index),
        .status(status),
        .frame_type(frame_type),
        .sequence_res(sequence_res),
        .payload_length(payload_length),
        .last(last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bit-serial form of the reflected CRC-16 update.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb)
                r = r ^ crcfp_pkg::CRC_POLY;
        end
        return r;
    endfunction

    // Works out the results that one accepted byte causes and queues them.
    task automatic parse_byte(input logic [7:0] b, input logic eob);
        crcfp_pkg::res_t r;
        int   c;
        c = int'(m_count);
        case (c)
            0: m_magic = {8'h00, b};
            1: m_magic[15:8] = b;
            2: m_version = b;
            3: m_type = b;
            4: m_seq = {24'h000000, b};
            5: m_seq[15:8] = b;
            6: m_seq[23:16] = b;
            7: m_seq[31:24] = b;
            8: m_len = {8'h00, b};
            9: m_len[15:8] = b;
            10: m_rx_crc = {8'h00, b};
            11: m_rx_crc[15:8] = b;
            default: ;
        endcase

        if (c < crcfp_pkg::CRC_HDR_BYTES)
            m_crc = crc16_update(m_crc, b);
        else if (c >= crcfp_pkg::HDR_BYTES && c < crcfp_pkg::HDR_BYTES + int'(m_len))
        begin
            m_crc = crc16_update(m_crc, b);
            if (m_magic == cur_magic && m_version == cur_version && m_len <= cur_max_payload)
            begin
                r = '0;
                r.kind = crcfp_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = 16'(c - crcfp_pkg::HDR_BYTES);
                r.last = !eob;
                pending_results.push_back(r);
                payload_count++;
            end
        end

        if (m_count != crcfp_pkg::COUNT_MAX)
            m_count = m_count + 1'b1;

        if (eob)
        begin
            r = '0;
            r.kind = crcfp_pkg::KIND_STATUS;
            r.last = 1'b1;
            if (c + 1 < crcfp_pkg::HDR_BYTES)
                r.status = crcfp_pkg::ST_SHORT;
            else
            begin
                if (m_magic != cur_magic)
                    r.status = crcfp_pkg::ST_MAGIC;
                else if (m_version != cur_version)
                    r.status = crcfp_pkg::ST_VERSION;
                else if (m_len > cur_max_payload)
                    r.status = crcfp_pkg::ST_TOO_LONG;
                else if (c + 1 < crcfp_pkg::HDR_BYTES + int'(m_len))
                    r.status = crcfp_pkg::ST_TRUNCATED;
                else if (m_crc != m_rx_crc)
                    r.status = crcfp_pkg::ST_CRC;
                else
                    r.status = crcfp_pkg::ST_OK;
                r.frame_type = m_type;
                r.sequence_res = m_seq;
                r.payload_length = m_len;
            end
            pending_results.push_back(r);
            status_count[r.status]++;

            // The parser rearms for the next buffer.
            m_count = '0;
            m_crc = crcfp_pkg::CRC_INIT;
            m_magic = '0;
            m_version = '0;
            m_type = '0;
            m_seq = '0;
            m_len = '0;
            m_rx_crc = '0;
        end
    endtask

    function automatic string res_text(input crcfp_pkg::res_t r);
        return $sformatf("kind %0d byte %02h idx %0d st %0d type %02h seq %08h len %0d last %0d",
                         r.kind, r.payload_byte, r.payload_index, r.status, r.frame_type,
                         r.sequence_res, r.payload_length, r.last);
    endfunction

    task automatic check_result();
        crcfp_pkg::res_t got;
        crcfp_pkg::res_t exp_r;
        got = {kind, payload_byte, payload_index, status, frame_type, sequence_res,
               payload_length, last};
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("cycle %0d: result with nothing outstanding: %s", cycles, res_text(got));
        end
        else
        begin
            exp_r = pending_results.pop_front();
            if (got.kind !== exp_r.kind || got.payload_byte !== exp_r.payload_byte ||
                got.payload_index !== exp_r.payload_index || got.status !== exp_r.status ||
                got.frame_type !== exp_r.frame_type ||
                got.sequence_res !== exp_r.sequence_res ||
                got.payload_length !== exp_r.payload_length || got.last !== exp_r.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("cycle %0d: result mismatch", cycles);
                    $display("  expected %s", res_text(exp_r));
                    $display("  actual   %s", res_text(got));
                end
            end
        end
    endtask

    // Both channels are sampled at the falling edge, where nothing is changing;
    // a transfer seen there completes at the following rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_byte(in_byte, end_of_buffer);
                bytes_in++;
            end
            if (byte_valid && byte_stall)
                stall_cycles++;
            if (res_valid && !res_stall)
                check_result();
        end
    end

    // Result sink: a random wait before each transfer.
    initial
    begin : result_sink
        int gap;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            gap = rx_jitter ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                rx_wait <= 1'b1;
                repeat (gap) @(posedge clk);
                rx_wait <= 1'b0;
            end
            do @(negedge clk); while (!(res_valid && !res_stall));
            @(posedge clk);
        end
    end

    // Long hold-off of the sink, requested by the back-pressure test.
    initial
    begin : sink_hold
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                rx_hold <= 1'b1;
                repeat (hold_req) @(posedge clk);
                rx_hold <= 1'b0;
                hold_req = 0;
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
    end

    // Offers one byte after a random gap and returns at the edge of its transfer.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = tx_jitter ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte <= b;
        end_of_buffer <= eob;
        do @(negedge clk); while (byte_stall);
        @(posedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Header with a correct CRC, followed by body_n random payload bytes.
    function automatic void build_frame(input logic [15:0] mg, input logic [7:0] vr,
                                        input logic [7:0] ty, input logic [31:0] sq,
                                        input logic [15:0] len, input int body_n);
        logic [7:0]  body[$];
        logic [15:0] crc;
        frame_buf.delete();
        frame_buf.push_back(mg[7:0]);
        frame_buf.push_back(mg[15:8]);
        frame_buf.push_back(vr);
        frame_buf.push_back(ty);
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(sq[8*i +: 8]);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        crc = crcfp_pkg::CRC_INIT;
        for (int i = 0; i < crcfp_pkg::CRC_HDR_BYTES; i++)
            crc = crc16_update(crc, frame_buf[i]);
        for (int i = 0; i < body_n; i++)
        begin
            body.push_back(8'($urandom));
            crc = crc16_update(crc, body[i]);
        end
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        for (int i = 0; i < body_n; i++)
            frame_buf.push_back(body[i]);
    endfunction

    task automatic send_frame(input logic [15:0] mg, input logic [7:0] vr, input logic [7:0] ty,
                              input logic [31:0] sq, input logic [15:0] len, input int body_n);
        build_frame(mg, vr, ty, sq, len, body_n);
        send_buffer();
    endtask

    // Lets every outstanding result drain before anything is reconfigured.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] mg, input logic [7:0] vr, input logic [15:0] mx);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= crcfp_pkg::REG_MAGIC;
        cfg_wdata <= mg;
        @(posedge clk);
        cfg_index <= crcfp_pkg::REG_VERSION;
        cfg_wdata <= {8'h00, vr};
        @(posedge clk);
        cfg_index <= crcfp_pkg::REG_MAX_PAYLOAD;
        cfg_wdata <= mx;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_magic = mg;
        cur_version = vr;
        cur_max_payload = mx;
    endtask

    // Reset register values: magic and version zero, payload limit 1024.
    task automatic test_reset_defaults();
        send_frame(16'h0000, 8'h00, 8'hFF, 32'hFFFF_FFFF, 16'd3, 3);
        send_frame(16'h0000, 8'h00, 8'h00, 32'h0000_0000, 16'd0, 0);
    endtask

    task automatic test_short_buffers();
        send_byte(8'hFF, 1'b1);
        build_frame(16'h0000, 8'h00, 8'h5A, 32'h1234_5678, 16'd0, 0);
        frame_buf.pop_back();
        send_buffer();
    endtask

    // One failure per frame, plus a frame where magic and version are both wrong.
    task automatic test_header_checks();
        set_config(16'hA55A, 8'h5C, 16'd6);
        build_frame(cur_magic, cur_version, 8'h11, 32'h0000_0001, 16'd2, 2);
        frame_buf[1] = frame_buf[1] ^ 8'h80;
        send_buffer();
        build_frame(cur_magic, cur_version, 8'h12, 32'h0000_0002, 16'd2, 2);
        frame_buf[0] = frame_buf[0] ^ 8'h01;
        frame_buf[2] = frame_buf[2] ^ 8'h01;
        send_buffer();
        build_frame(cur_magic, cur_version, 8'h13, 32'h0000_0003, 16'd2, 2);
        frame_buf[2] = frame_buf[2] ^ 8'hFF;
        send_buffer();
        send_frame(cur_magic, cur_version, 8'h14, 32'h0000_0004, 16'd7, 2);
        build_frame(cur_magic, cur_version, 8'h15, 32'h0000_0005, 16'd5, 5);
        repeat (3) frame_buf.pop_back();
        send_buffer();
        build_frame(cur_magic, cur_version, 8'h16, 32'h0000_0006, 16'd3, 3);
        frame_buf[13] = frame_buf[13] ^ 8'h40;
        send_buffer();
    endtask

    // A payload byte that ends the buffer, then bytes trailing after the payload.
    task automatic test_payload_stream();
        send_frame(cur_magic, cur_version, 8'h21, 32'hCAFE_0001, 16'd6, 6);
        build_frame(cur_magic, cur_version, 8'h22, 32'hCAFE_0002, 16'd2, 2);
        repeat (3) frame_buf.push_back(8'($urandom));
        send_buffer();
    endtask

    task automatic test_register_extremes();
        set_config(16'hFFFF, 8'hFF, 16'd0);
        send_frame(cur_magic, cur_version, 8'h31, 32'h8000_0000, 16'd0, 0);
        send_frame(cur_magic, cur_version, 8'h32, 32'h0000_0080, 16'd1, 1);
        set_config(16'h0000, 8'h00, 16'hFFFF);
        send_frame(cur_magic, cur_version, 8'h33, 32'h7FFF_FFFF, 16'hFFFF, 3);
    endtask

    // A buffer that runs far past an empty payload: the extra bytes cause nothing.
    task automatic test_long_buffer();
        int n;
        n = crcfp_pkg::HDR_BYTES + LONG_TRAIL;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        set_config(16'h1234, 8'h02, 16'd8);
        build_frame(cur_magic, cur_version, 8'h3C, 32'h0BAD_F00D, 16'd0, 0);
        for (int i = 0; i < n; i++)
            send_byte(i < crcfp_pkg::HDR_BYTES ? frame_buf[i] : 8'($urandom), i == n - 1);
        wait_idle();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    // The sink holds off while bytes keep coming, so the result queue fills.
    task automatic test_backpressure();
        set_config(16'hBEEF, 8'h07, 16'd64);
        tx_jitter = 1'b0;
        hold_req = 150;
        send_frame(cur_magic, cur_version, 8'h44, 32'hDEAD_BEEF, 16'd40, 40);
        wait_idle();
        tx_jitter = 1'b1;
    endtask

    task automatic test_random_frames();
        int sent;
        int frames;
        int len;
        int lim;
        int n;
        int trail;
        bit clean;
        sent = 0;
        frames = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (frames % 4 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: set_config(16'hFFFF, 8'hFF, 16'hFFFF);
                    1: set_config(16'h0000, 8'h00, 16'd0);
                    2: set_config(16'($urandom), 8'($urandom), 16'($urandom));
                    3: set_config(16'($urandom), 8'($urandom), 16'($urandom_range(0, 40)));
                    default: set_config(16'($urandom), 8'($urandom), 16'($urandom_range(0, 16)));
                endcase
                tx_jitter = $urandom_range(0, 3) != 0;
                rx_jitter = $urandom_range(0, 3) != 0;
            end
            frames++;
            lim = cur_max_payload < 16 ? int'(cur_max_payload) : 16;
            len = $urandom_range(0, lim);
            build_frame(cur_magic, cur_version, 8'($urandom), $urandom, 16'(len), len);
            clean = 1'b0;
            case ($urandom_range(0, 15))
                0:
                begin
                    // Noise with no frame structure at all.
                    frame_buf.delete();
                    repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
                end
                1:
                begin
                    n = $urandom_range(1, crcfp_pkg::HDR_BYTES - 1);
                    while (frame_buf.size() > n)
                        frame_buf.pop_back();
                end
                2:
                begin
                    n = $urandom_range(0, 1);
                    frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
                end
                3: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
                4:
                begin
                    if (cur_max_payload != 16'hFFFF)
                    begin
                        len = int'(cur_max_payload) + $urandom_range(1, 300);
                        if (len > 65535)
                            len = 65535;
                        build_frame(cur_magic, cur_version, 8'($urandom), $urandom, 16'(len),
                                    $urandom_range(0, 4));
                    end
                end
                5:
                begin
                    if (len > 0)
                        repeat ($urandom_range(1, len)) frame_buf.pop_back();
                end
                6:
                begin
                    n = len > 0 ? $urandom_range(crcfp_pkg::HDR_BYTES,
                                                 crcfp_pkg::HDR_BYTES + len - 1)
                                : $urandom_range(10, 11);
                    frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
                end
                default: clean = 1'b1;
            endcase
            trail = 0;
            if (clean && $urandom_range(0, 3) == 0)
            begin
                trail = $urandom_range(1, 4);
                repeat (trail) frame_buf.push_back(8'($urandom));
            end
            sent += frame_buf.size() - trail;
            send_buffer();
        end
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            status_count[i] = 0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        in_byte = 8'h00;
        end_of_buffer = 1'b0;
        cfg_we = 1'b0;
        cfg_index = crcfp_pkg::REG_MAGIC;
        cfg_wdata = 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_short_buffers();
        test_header_checks();
        test_payload_stream();
        test_register_extremes();
        test_backpressure();
        test_long_buffer();
        test_random_frames();
        wait_idle();

        $display("run: %0d bytes in, %0d payload bytes and %0d frame reports out, %0d stalled",
                 bytes_in, payload_count,
                 status_count[0] + status_count[1] + status_count[2] + status_count[3] +
                 status_count[4] + status_count[5] + status_count[6], stall_cycles);
        $display("run: ok %0d, short %0d, magic %0d, version %0d, long %0d, cut %0d, crc %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4], status_count[5], status_count[6]);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
